@@ rtl/eg_pkg.sv @@
// Shared types and constants for the extended GCD block.
package eg_pkg;

    localparam int EG_WIDTH = 64;
    localparam int FIELD_W  = 64;
    localparam int IN_W     = 2 * FIELD_W;
    localparam int OUT_W    = 3 * FIELD_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_TEST  = 5'b00010,
        S_ALIGN = 5'b00100,
        S_DIV   = 5'b01000,
        S_UPD   = 5'b10000
    } t_state;

    typedef struct packed {
        logic load;
        logic start;
        logic align;
        logic divide;
        logic update;
    } t_eg_ctrl;

    typedef struct packed {
        logic ge;
        logic k_zero;
        logic y_zero;
    } t_eg_stat;

endpackage

@@ rtl/extended_gcd.sv @@
// Top level of the extended GCD block: sequencer, remainder unit, coefficient units, output register.
//
// The block takes one operand pair per transfer and returns the greatest common divisor with
// Bezout coefficients so that coeff_x*x + coeff_y*y equals the divisor modulo 2^WIDTH; a zero
// second operand gives (x, 1, 0), and operand bits above WIDTH are ignored. Each Euclid step
// aligns the divisor one bit a cycle, then produces one quotient bit a cycle on the shared
// compare-subtract unit, and the coefficient products build up alongside by shift and add.
// The input is not ready while an item is at work; a finished result waits in the output
// register, and the next item can be taken while it waits.
module extended_gcd import eg_pkg::*; #(
    parameter int WIDTH = EG_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // operand_x, operand_y
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata    // gcd_value, coeff_x, coeff_y
);

    t_eg_ctrl         ctrl;
    t_eg_stat         stat;
    logic             qbit;
    logic             capture;
    logic             out_free;
    logic [WIDTH-1:0] gcd;
    logic [WIDTH-1:0] coef_a;
    logic [WIDTH-1:0] coef_b;

    logic               r_out_valid;
    logic [FIELD_W-1:0] r_gcd;
    logic [FIELD_W-1:0] r_cx;
    logic [FIELD_W-1:0] r_cy;

    assign out_free = !r_out_valid || m_axis_tready;

    eg_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_in_ready (s_axis_tready),
        .o_capture  (capture),
        .o_ctrl     (ctrl)
    );

    eg_div #(.WIDTH(WIDTH)) u_div (
        .i_clk  (i_clk),
        .i_ctrl (ctrl),
        .i_x    (s_axis_tdata[WIDTH-1:0]),
        .i_y    (s_axis_tdata[FIELD_W+WIDTH-1:FIELD_W]),
        .o_stat (stat),
        .o_qbit (qbit),
        .o_gcd  (gcd)
    );

    eg_coef #(.WIDTH(WIDTH)) u_coef_a (
        .i_clk       (i_clk),
        .i_ctrl      (ctrl),
        .i_init_prev (1'b1),
        .i_init_cur  (1'b0),
        .i_qbit      (qbit),
        .o_prev      (coef_a)
    );

    eg_coef #(.WIDTH(WIDTH)) u_coef_b (
        .i_clk       (i_clk),
        .i_ctrl      (ctrl),
        .i_init_prev (1'b0),
        .i_init_cur  (1'b1),
        .i_qbit      (qbit),
        .o_prev      (coef_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (capture) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (capture) begin
            r_gcd <= FIELD_W'(gcd);
            r_cx  <= FIELD_W'($signed(coef_a));
            r_cy  <= FIELD_W'($signed(coef_b));
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_cy, r_cx, r_gcd};

endmodule

@@ rtl/eg_div.sv @@
// Remainder datapath: shared compare-subtract unit with divisor alignment.
module eg_div import eg_pkg::*; #(
    parameter int WIDTH = EG_WIDTH
) (
    input  logic             i_clk,
    input  t_eg_ctrl         i_ctrl,
    input  logic [WIDTH-1:0] i_x,
    input  logic [WIDTH-1:0] i_y,
    output t_eg_stat         o_stat,
    output logic             o_qbit,
    output logic [WIDTH-1:0] o_gcd
);

    localparam int KW = $clog2(WIDTH);

    logic [WIDTH-1:0] r_x, n_x;
    logic [WIDTH-1:0] r_y, n_y;
    logic [WIDTH-1:0] r_rem, n_rem;
    logic [WIDTH-1:0] r_dvs, n_dvs;
    logic [KW-1:0]    r_k, n_k;

    logic [WIDTH:0]   cmp_b;
    logic             ge;
    logic [WIDTH-1:0] diff;

    assign cmp_b = i_ctrl.align ? {r_dvs, 1'b0} : {1'b0, r_dvs};
    assign ge    = {1'b0, r_rem} >= cmp_b;
    assign diff  = r_rem - r_dvs;

    always_comb begin
        n_x   = r_x;
        n_y   = r_y;
        n_rem = r_rem;
        n_dvs = r_dvs;
        n_k   = r_k;
        if (i_ctrl.load) begin
            n_x = i_x;
            n_y = i_y;
        end
        if (i_ctrl.start) begin
            n_rem = r_x;
            n_dvs = r_y;
            n_k   = '0;
        end
        if (i_ctrl.align && ge) begin
            n_dvs = {r_dvs[WIDTH-2:0], 1'b0};
            n_k   = KW'(r_k + 1'b1);
        end
        if (i_ctrl.divide) begin
            if (ge) begin
                n_rem = diff;
            end
            n_dvs = {1'b0, r_dvs[WIDTH-1:1]};
            n_k   = KW'(r_k - 1'b1);
        end
        if (i_ctrl.update) begin
            n_x = r_y;
            n_y = r_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_y   <= n_y;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_k   <= n_k;
    end

    assign o_stat.ge     = ge;
    assign o_stat.k_zero = (r_k == '0);
    assign o_stat.y_zero = (r_y == '0);
    assign o_qbit        = i_ctrl.divide & ge;
    assign o_gcd         = r_x;

endmodule

@@ rtl/eg_coef.sv @@
// One Bezout coefficient pair with a shift-add accumulator for quotient times coefficient.
module eg_coef import eg_pkg::*; #(
    parameter int WIDTH = EG_WIDTH
) (
    input  logic             i_clk,
    input  t_eg_ctrl         i_ctrl,
    input  logic             i_init_prev,
    input  logic             i_init_cur,
    input  logic             i_qbit,
    output logic [WIDTH-1:0] o_prev
);

    logic [WIDTH-1:0] r_prev, n_prev;
    logic [WIDTH-1:0] r_cur, n_cur;
    logic [WIDTH-1:0] r_acc, n_acc;

    always_comb begin
        n_prev = r_prev;
        n_cur  = r_cur;
        n_acc  = r_acc;
        if (i_ctrl.load) begin
            n_prev = WIDTH'(i_init_prev);
            n_cur  = WIDTH'(i_init_cur);
        end
        if (i_ctrl.start) begin
            n_acc = '0;
        end
        if (i_ctrl.divide) begin
            n_acc = {r_acc[WIDTH-2:0], 1'b0} + (i_qbit ? r_cur : '0);
        end
        if (i_ctrl.update) begin
            n_prev = r_cur;
            n_cur  = r_prev - r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev <= n_prev;
        r_cur  <= n_cur;
        r_acc  <= n_acc;
    end

    assign o_prev = r_prev;

endmodule

@@ rtl/eg_seq.sv @@
// Sequencer that steps the shared units through each Euclid iteration.
module eg_seq import eg_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_out_free,
    input  t_eg_stat i_stat,
    output logic     o_in_ready,
    output logic     o_capture,
    output t_eg_ctrl o_ctrl
);

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_ctrl     = '0;
        o_in_ready = 1'b0;
        o_capture  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctrl.load = 1'b1;
                    n_state     = S_TEST;
                end
            end
            S_TEST: begin
                if (i_stat.y_zero) begin
                    if (i_out_free) begin
                        o_capture = 1'b1;
                        n_state   = S_IDLE;
                    end
                end else begin
                    o_ctrl.start = 1'b1;
                    n_state      = S_ALIGN;
                end
            end
            S_ALIGN: begin
                o_ctrl.align = 1'b1;
                if (!i_stat.ge) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_ctrl.divide = 1'b1;
                if (i_stat.k_zero) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_ctrl.update = 1'b1;
                n_state       = S_TEST;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/eg_chk.sv @@
// Port-level checker for the extended GCD block and its bind to the top level.
module eg_chk import eg_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic [IN_W-1:0]  s_axis_tdata,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Result changed or dropped while stalled.");

    a_busy_after_in : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !$rose(m_axis_tvalid))
        else $error("Input ready or result shown right after an input transfer.");

    a_zero_gcd : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[FIELD_W-1:0] == '0) |->
        (m_axis_tdata[2*FIELD_W-1:FIELD_W] == FIELD_W'(1)) &&
        (m_axis_tdata[3*FIELD_W-1:2*FIELD_W] == '0))
        else $error("Zero divisor result without coefficients one and zero.");

    a_rose_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("Result presented while the block was still busy.");

endmodule

bind extended_gcd eg_chk u_eg_chk (.*);

@@ tb/sv/extended_gcd_tb.sv @@
// Self-checking testbench for the extended GCD block: directed cases, random operand pairs, stalls.
module extended_gcd_tb;
    import eg_pkg::*;

    localparam int          N_DIRECTED   = 19;
    localparam int          N_PHASES     = 4;
    localparam int          PHASE_ITEMS  = 225;
    localparam int          HOLD_AT      = N_DIRECTED + 8;
    localparam int          HOLD_CYCLES  = 3000;
    localparam int          DRAIN_CYCLES = 800;
    localparam int          CYCLE_LIMIT  = 10000000;
    localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] LANE_MASK    = ALL_ONES >> (64 - EG_WIDTH);

    typedef struct packed {
        logic signed [63:0] coeff_y;
        logic signed [63:0] coeff_x;
        logic        [63:0] gcd_value;
    } bezout_t;

    typedef struct {
        logic [63:0] x;
        logic [63:0] y;
        bezout_t     res;
    } bezout_due_t;

    typedef struct {
        logic [63:0] x;
        logic [63:0] y;
        bit          fixed;
        logic [63:0] gcd_value;
        logic [63:0] coeff_x;
        logic [63:0] coeff_y;
    } gcd_case_t;

    // Rows marked fixed carry their expected result; the others go through the predictor.
    gcd_case_t directed_cases [N_DIRECTED] = '{
        '{64'd0, 64'd0, 1'b1, 64'd0, 64'd1, 64'd0},
        '{64'd5, 64'd0, 1'b1, 64'd5, 64'd1, 64'd0},
        '{ALL_ONES, 64'd0, 1'b1, ALL_ONES, 64'd1, 64'd0},
        '{64'd0, 64'd7, 1'b1, 64'd7, 64'd0, 64'd1},
        '{64'd0, ALL_ONES, 1'b1, ALL_ONES, 64'd0, 64'd1},
        '{64'd1, 64'd1, 1'b0, 64'd0, 64'd0, 64'd0},
        '{ALL_ONES, ALL_ONES, 1'b0, 64'd0, 64'd0, 64'd0},
        '{ALL_ONES, 64'd1, 1'b0, 64'd0, 64'd0, 64'd0},
        '{64'd1, ALL_ONES, 1'b0, 64'd0, 64'd0, 64'd0},
        '{ALL_ONES, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 64'd0, 64'd0, 64'd0},
        '{64'd240, 64'd46, 1'b0, 64'd0, 64'd0, 64'd0},
        '{64'd12, 64'd18, 1'b0, 64'd0, 64'd0, 64'd0},
        '{64'd12200160415121876738, 64'd7540113804746346429, 1'b0, 64'd0, 64'd0, 64'd0},
        '{64'd7540113804746346429, 64'd12200160415121876738, 1'b0, 64'd0, 64'd0, 64'd0},
        '{64'h8000_0000_0000_0000, 64'h4000_0000_0000_0000, 1'b0, 64'd0, 64'd0, 64'd0},
        '{64'h8000_0000_0000_0000, 64'd3, 1'b0, 64'd0, 64'd0, 64'd0},
        '{64'd18446744073709551557, 64'h8000_0000_0000_0000, 1'b0, 64'd0, 64'd0, 64'd0},
        '{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0, 64'd0, 64'd0, 64'd0},
        '{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'd0, 64'd0, 64'd0}
    };

    int src_idle_pcts   [N_PHASES] = '{0, 83, 0, 36};
    int sink_stall_pcts [N_PHASES] = '{0, 0, 83, 36};

    logic             i_clk;
    logic             i_rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata;   // operand_x, operand_y
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;   // gcd_value, coeff_x, coeff_y

    bit          offer_fixed;
    bezout_t     offer_want;
    bezout_due_t bezout_due_q [$];

    int src_idle_pct       = 0;
    int sink_stall_pct     = 0;
    int pairs_accepted     = 0;
    int results_checked    = 0;
    int mismatches         = 0;
    int input_stall_cycles = 0;
    int cycles             = 0;
    bit hold_done          = 1'b0;

    extended_gcd DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic logic [63:0] sign_widen(input logic [63:0] v);
        logic [63:0] w;
        w = v & LANE_MASK;
        if (w[EG_WIDTH-1]) begin
            w = w | ~LANE_MASK;
        end
        return w;
    endfunction

    // Euclid remainder sequence with both coefficient pairs carried along, wrapping at WIDTH.
    function automatic bezout_t bezout_of(input logic [63:0] x_in, input logic [63:0] y_in);
        logic [63:0] x, y, q, r, t, pa, ca, pb, cb;
        bezout_t     res;
        x  = x_in & LANE_MASK;
        y  = y_in & LANE_MASK;
        pa = 64'd1;
        ca = 64'd0;
        pb = 64'd0;
        cb = 64'd1;
        while (y != 64'd0) begin
            q  = x / y;
            r  = x % y;
            x  = y;
            y  = r;
            t  = ca;
            ca = (pa - ca * q) & LANE_MASK;
            pa = t;
            t  = cb;
            cb = (pb - cb * q) & LANE_MASK;
            pb = t;
        end
        res.gcd_value = x & LANE_MASK;
        res.coeff_x   = sign_widen(pa);
        res.coeff_y   = sign_widen(pb);
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int idle_len(input int pct);
        int n;
        n = 0;
        if (pct == 0) begin
            return 0;
        end
        if ($urandom_range(99) < 5) begin
            return $urandom_range(1, 700);
        end
        while ($urandom_range(99) < pct) begin
            n++;
        end
        return n;
    endfunction

    task automatic draw_operands(output logic [63:0] x, output logic [63:0] y);
        int          kind;
        int          n;
        logic [63:0] g, a, b, t;
        kind = $urandom_range(99);
        if (kind < 30) begin
            x = rand64();
            y = rand64();
        end else if (kind < 50) begin
            x = rand64() >> $urandom_range(0, 63);
            y = rand64() >> $urandom_range(0, 63);
        end else if (kind < 65) begin
            g = rand64() >> $urandom_range(40, 63);
            x = g * (rand64() >> $urandom_range(32, 63));
            y = g * (rand64() >> $urandom_range(32, 63));
        end else if (kind < 73) begin
            y = rand64() >> $urandom_range(0, 63);
            x = y * 64'($urandom_range(1, 1000));
        end else if (kind < 80) begin
            n = $urandom_range(2, 92);
            a = 64'd0;
            b = 64'd1;
            repeat (n) begin
                t = a + b;
                a = b;
                b = t;
            end
            x = b;
            y = a;
        end else if (kind < 86) begin
            x = $urandom_range(3) == 0 ? 64'd0 : rand64() >> $urandom_range(0, 63);
            y = 64'd0;
        end else if (kind < 93) begin
            x = ~(rand64() >> $urandom_range(8, 63));
            y = ~(rand64() >> $urandom_range(8, 63));
        end else begin
            x = 64'($urandom_range(15));
            y = $urandom_range(1) ? x : 64'($urandom_range(15));
        end
        if ($urandom_range(1)) begin
            t = x;
            x = y;
            y = t;
        end
    endtask

    task automatic offer_pair(input logic [63:0] x, input logic [63:0] y, input bit fixed,
                              input bezout_t want);
        int gap;
        gap = idle_len(src_idle_pct);
        repeat (gap) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y, x};
        offer_fixed   <= fixed;
        offer_want    <= want;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [63:0] x, input logic [63:0] y,
                               input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch in %s for x=%h y=%h: expected %h, got %h",
                         name, x, y, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin : scoreboard
        bezout_due_t due;
        bezout_t     got;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                due.x   = s_axis_tdata[63:0];
                due.y   = s_axis_tdata[127:64];
                due.res = offer_fixed ? offer_want : bezout_of(due.x, due.y);
                bezout_due_q.push_back(due);
                pairs_accepted++;
            end else if (s_axis_tvalid) begin
                input_stall_cycles++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (bezout_due_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result transfer with nothing pending: %h", m_axis_tdata);
                    end
                end else begin
                    due = bezout_due_q.pop_front();
                    results_checked++;
                    check_field("gcd_value", due.x, due.y, due.res.gcd_value, got.gcd_value);
                    check_field("coeff_x", due.x, due.y, due.res.coeff_x, got.coeff_x);
                    check_field("coeff_y", due.x, due.y, due.res.coeff_y, got.coeff_y);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, bezout_due_q.size());
            $display("status: fail");
            $finish;
        end
    end

    // The output side stalls at random; once, early on, it holds off long enough that
    // the block fills up and stops taking operands.
    initial begin : sink
        int n;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && pairs_accepted >= HOLD_AT) begin
                for (n = 0; n < HOLD_CYCLES; n++) begin
                    m_axis_tready <= 1'b0;
                    @(negedge i_clk);
                end
                hold_done = 1'b1;
            end
            n = idle_len(sink_stall_pct);
            repeat (n) begin
                m_axis_tready <= 1'b0;
                @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    initial begin : stimulus
        logic [63:0] x, y;
        bezout_t     want;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        offer_fixed   = 1'b0;
        offer_want    = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_cases[i]) begin
            want = '{coeff_y: directed_cases[i].coeff_y, coeff_x: directed_cases[i].coeff_x,
                     gcd_value: directed_cases[i].gcd_value};
            offer_pair(directed_cases[i].x, directed_cases[i].y, directed_cases[i].fixed, want);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            src_idle_pct   = src_idle_pcts[p];
            sink_stall_pct = sink_stall_pcts[p];
            @(negedge i_clk);
            repeat (PHASE_ITEMS) begin
                draw_operands(x, y);
                offer_pair(x, y, 1'b0, '0);
            end
        end
        s_axis_tvalid <= 1'b0;

        while (bezout_due_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d operand pairs sent (%0d directed), %0d results checked, %0d mismatches",
                 pairs_accepted, N_DIRECTED, results_checked, mismatches);
        $display("idling phases: none, sender, receiver, both; input stalled %0d cycles",
                 input_stall_cycles);
        if (mismatches == 0 && bezout_due_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
